### rtl/ccm_pkg.sv
// Shared types, codes and AES helper functions for the CCM byte stream core.
// Used by every module in rtl/; depends on nothing else.
package ccm_pkg;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_tag;
        logic       last;
        logic [1:0] error;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_B0,
        ST_KS,
        ST_DATA,
        ST_MAC,
        ST_A0,
        ST_TAG
    } t_state;

    localparam logic       OP_DATA   = 1'b0;
    localparam logic       OP_FINISH = 1'b1;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_HEADER = 2'd1;
    localparam logic [1:0] ERR_EXTRA  = 2'd2;
    localparam logic [1:0] ERR_EARLY  = 2'd3;

    localparam int         CFG_IDX_W      = 3;
    localparam logic [2:0] CFG_KEY_HIGH   = 3'd0;
    localparam logic [2:0] CFG_KEY_LOW    = 3'd1;
    localparam logic [2:0] CFG_NONCE_HIGH = 3'd2;
    localparam logic [2:0] CFG_NONCE_LOW  = 3'd3;
    localparam logic [2:0] CFG_MSG_LEN    = 3'd4;
    localparam logic [2:0] CFG_HDR_LEN    = 3'd5;
    localparam logic [2:0] CFG_DIRECTION  = 3'd6;

    localparam int         CCM_L       = 2;
    localparam logic [7:0] A_FLAGS     = 8'(CCM_L - 1);
    localparam int         AES_ROUNDS  = 10;
    localparam int         Q_DEPTH     = 2;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] f_xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Next AES-128 round key from the current one and its round constant.
    function automatic logic [127:0] f_key_next(input logic [127:0] k, input logic [7:0] rcon);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t  = {SBOX[k[23:16]] ^ rcon, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // One AES round: SubBytes, ShiftRows, MixColumns unless final, AddRoundKey.
    function automatic logic [127:0] f_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic fin);
        logic [7:0]   t [16];
        logic [7:0]   m [16];
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[j + 4 * c] = SBOX[s[127 - 8 * (j + 4 * ((c + j) % 4)) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[4 * c]     = f_xt(t[4*c]) ^ f_xt(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4 * c + 1] = t[4*c] ^ f_xt(t[4*c+1]) ^ f_xt(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
            m[4 * c + 2] = t[4*c] ^ t[4*c+1] ^ f_xt(t[4*c+2]) ^ f_xt(t[4*c+3]) ^ t[4*c+3];
            m[4 * c + 3] = f_xt(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ f_xt(t[4*c+3]);
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8 * i -: 8] = (fin ? t[i] : m[i]) ^ rk[127 - 8 * i -: 8];
        end
        return r;
    endfunction

endpackage

### rtl/aes_ccm_stream_crypt_core.sv
// Top level of the AES-128 CCM byte stream core (L = 2).
// Depends on ccm_pkg, ccm_front, ccm_back and ccm_aes.
//
//  channel | direction | handshake            | payload
//  in      | to core   | i_in_valid/o_in_stall | i_in_item  (t_in_item)
//  out     | from core | o_out_valid/i_out_stall | o_out_item (t_out_item)
//  cfg     | to core   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A data byte passes through the back end's ST_IDLE and ST_DATA states, plus one AES run
// for each encryption it triggers (B0 at run start, a keystream block every 16 bytes after
// the header, a MAC block every 16 bytes and at message end) in the iterative AES unit.
// A finish item costs one AES run for A0, then one tag byte per cycle while the output
// is not stalled. Reset is synchronous and active low; configuration is always ready.
// The two-entry input queue and the output register let either side stall independently.
module aes_ccm_stream_crypt_core import ccm_pkg::*; #(
    parameter int TAG_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);
    logic     q_valid;
    t_in_item q_item;
    logic     q_pop;

    assign o_cfg_ready = 1'b1;

    ccm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    ccm_back #(
        .TAG_BYTES (TAG_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

### rtl/ccm_front.sv
// Front end: accepts input items into a short queue for the back end.
// Depends on ccm_pkg.
module ccm_front import ccm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    output logic     o_q_valid,
    output t_in_item o_q_item,
    input  logic     i_q_pop
);
    localparam int PW = $clog2(Q_DEPTH);

    t_in_item          r_mem [Q_DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [PW:0]       r_count;
    logic              push;

    assign o_in_stall = (r_count == (PW+1)'(Q_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd <= (r_rd == PW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + (PW+1)'(push) - (PW+1)'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_in_item;
        end
    end

endmodule

### rtl/ccm_aes.sv
// Iterative AES-128 encryption, one round per cycle, key schedule on the fly.
// Depends on ccm_pkg.
module ccm_aes import ccm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_block,
    input  logic [127:0] i_key,
    output logic         o_done,
    output logic [127:0] o_result
);
    logic         r_busy;
    logic         r_done;
    logic [3:0]   r_round;
    logic [7:0]   r_rcon;
    logic [127:0] r_key;
    logic [127:0] r_state;
    logic [127:0] n_key;
    logic         last;

    assign n_key    = f_key_next(r_key, r_rcon);
    assign last     = (r_round == 4'(AES_ROUNDS));
    assign o_done   = r_done;
    assign o_result = r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= 4'd1;
            end else if (r_busy) begin
                r_round <= r_round + 4'd1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_state <= i_block ^ i_key;
            r_key   <= i_key;
            r_rcon  <= 8'h01;
        end else if (r_busy) begin
            r_state <= f_round(r_state, n_key, last);
            r_key   <= n_key;
            r_rcon  <= f_xt(r_rcon);
        end
    end

endmodule

### rtl/ccm_back.sv
// Back end: holds configuration and run state, sequences the AES unit and
// drives the output register. Depends on ccm_pkg and ccm_aes.
module ccm_back import ccm_pkg::*; #(
    parameter int TAG_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_q_valid,
    input  t_in_item             i_q_item,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item
);
    localparam int         TW       = $clog2(TAG_BYTES);
    localparam logic [7:0] B0_FLAGS = 8'(((TAG_BYTES - 2) / 2) * 8 + CCM_L - 1);

    logic [63:0]  r_key_high, r_key_low, r_nonce_high;
    logic [39:0]  r_nonce_low;
    logic [15:0]  r_msg_len, r_hdr_len;
    logic         r_direction;

    t_state       r_state, n_state;
    logic [127:0] r_chain, n_chain;
    logic [127:0] r_block, n_block;
    logic [127:0] r_ks, n_ks;
    logic [16:0]  r_pos, n_pos;
    logic [15:0]  r_ctr, n_ctr;
    logic         r_started, n_started;
    logic         r_op, n_op;
    logic [7:0]   r_d, n_d;
    logic [TW-1:0] r_tag_idx, n_tag_idx;
    logic         r_out_valid, n_out_valid;
    t_out_item    r_out, n_out;

    logic         aes_start;
    logic [127:0] aes_block;
    logic         aes_done;
    logic [127:0] aes_result;

    logic [103:0] nonce;
    logic         out_free;
    logic [1:0]   head_err;
    logic         need_ks;
    logic         in_hdr;
    logic [3:0]   slot;
    logic [3:0]   kidx;
    logic [7:0]   o_byte;
    logic [7:0]   p_byte;
    logic [127:0] v_blk;
    logic         clear_run;

    ccm_aes u_aes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (aes_start),
        .i_block  (aes_block),
        .i_key    ({r_key_high, r_key_low}),
        .o_done   (aes_done),
        .o_result (aes_result)
    );

    assign nonce       = {r_nonce_high, r_nonce_low};
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign in_hdr      = (r_pos < {1'b0, r_hdr_len});
    assign kidx        = r_pos[3:0] - r_hdr_len[3:0];
    assign slot        = r_pos[3:0];
    assign need_ks     = !in_hdr && (kidx == 4'd0);
    assign o_byte      = in_hdr ? r_d : (r_d ^ r_ks[127 - 8 * kidx -: 8]);
    assign p_byte      = (in_hdr || !r_direction) ? r_d : o_byte;

    always_comb begin
        if (r_hdr_len > r_msg_len) begin
            head_err = ERR_HEADER;
        end else if (i_q_item.opcode == OP_DATA) begin
            head_err = (r_pos >= {1'b0, r_msg_len}) ? ERR_EXTRA : ERR_NONE;
        end else begin
            head_err = (r_pos != {1'b0, r_msg_len}) ? ERR_EARLY : ERR_NONE;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_chain     = r_chain;
        n_block     = r_block;
        n_ks        = r_ks;
        n_pos       = r_pos;
        n_ctr       = r_ctr;
        n_started   = r_started;
        n_op        = r_op;
        n_d         = r_d;
        n_tag_idx   = r_tag_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        aes_start   = 1'b0;
        aes_block   = r_chain ^ r_block;
        o_q_pop     = 1'b0;
        clear_run   = 1'b0;
        v_blk       = r_block;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (head_err != ERR_NONE) begin
                        if (out_free) begin
                            o_q_pop     = 1'b1;
                            n_out_valid = 1'b1;
                            n_out       = '{out_byte: 8'h00, is_tag: 1'b0, last: 1'b1,
                                            error: head_err};
                            clear_run   = 1'b1;
                        end
                    end else begin
                        o_q_pop = 1'b1;
                        n_op    = i_q_item.opcode;
                        n_d     = i_q_item.data_byte;
                        if (!r_started) begin
                            aes_start = 1'b1;
                            aes_block = {B0_FLAGS, nonce, r_msg_len};
                            n_state   = ST_B0;
                        end else if (i_q_item.opcode == OP_FINISH) begin
                            aes_start = 1'b1;
                            aes_block = {A_FLAGS, nonce, 16'h0000};
                            n_state   = ST_A0;
                        end else if (need_ks) begin
                            aes_start = 1'b1;
                            aes_block = {A_FLAGS, nonce, r_ctr};
                            n_state   = ST_KS;
                        end else begin
                            n_state = ST_DATA;
                        end
                    end
                end
            end
            ST_B0: begin
                if (aes_done) begin
                    n_chain   = aes_result;
                    n_block   = '0;
                    n_started = 1'b1;
                    if (r_op == OP_FINISH) begin
                        aes_start = 1'b1;
                        aes_block = {A_FLAGS, nonce, 16'h0000};
                        n_state   = ST_A0;
                    end else if (need_ks) begin
                        aes_start = 1'b1;
                        aes_block = {A_FLAGS, nonce, r_ctr};
                        n_state   = ST_KS;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_KS: begin
                if (aes_done) begin
                    n_ks    = aes_result;
                    n_ctr   = r_ctr + 16'd1;
                    n_state = ST_DATA;
                end
            end
            ST_DATA: begin
                if (out_free) begin
                    v_blk[127 - 8 * slot -: 8] = p_byte;
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: o_byte, is_tag: 1'b0, last: 1'b0,
                                    error: ERR_NONE};
                    n_pos       = r_pos + 17'd1;
                    // A full block, or the last byte of the message, folds into the MAC.
                    if (slot == 4'd15 || (r_pos + 17'd1) == {1'b0, r_msg_len}) begin
                        aes_start = 1'b1;
                        aes_block = r_chain ^ v_blk;
                        n_block   = '0;
                        n_state   = ST_MAC;
                    end else begin
                        n_block = v_blk;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_MAC: begin
                if (aes_done) begin
                    n_chain = aes_result;
                    n_state = ST_IDLE;
                end
            end
            ST_A0: begin
                if (aes_done) begin
                    n_ks      = aes_result ^ r_chain;
                    n_tag_idx = '0;
                    n_state   = ST_TAG;
                end
            end
            ST_TAG: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: r_ks[127 - 8 * int'(r_tag_idx) -: 8],
                                    is_tag: 1'b1,
                                    last: (r_tag_idx == TW'(TAG_BYTES - 1)),
                                    error: ERR_NONE};
                    if (r_tag_idx == TW'(TAG_BYTES - 1)) begin
                        clear_run = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        n_tag_idx = r_tag_idx + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (clear_run) begin
            n_chain   = '0;
            n_block   = '0;
            n_ks      = '0;
            n_pos     = '0;
            n_ctr     = 16'd1;
            n_started = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high   <= '0;
            r_key_low    <= '0;
            r_nonce_high <= '0;
            r_nonce_low  <= '0;
            r_msg_len    <= '0;
            r_hdr_len    <= '0;
            r_direction  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                CFG_KEY_LOW:    r_key_low    <= i_cfg_data;
                CFG_NONCE_HIGH: r_nonce_high <= i_cfg_data;
                CFG_NONCE_LOW:  r_nonce_low  <= i_cfg_data[39:0];
                CFG_MSG_LEN:    r_msg_len    <= i_cfg_data[15:0];
                CFG_HDR_LEN:    r_hdr_len    <= i_cfg_data[15:0];
                CFG_DIRECTION:  r_direction  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chain     <= '0;
            r_block     <= '0;
            r_ks        <= '0;
            r_pos       <= '0;
            r_ctr       <= 16'd1;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chain     <= n_chain;
            r_block     <= n_block;
            r_ks        <= n_ks;
            r_pos       <= n_pos;
            r_ctr       <= n_ctr;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_d       <= n_d;
        r_tag_idx <= n_tag_idx;
        r_out     <= n_out;
    end

endmodule

### rtl/ccm_checker.sv
// Port-level checks for the CCM byte stream core, bound to the top level.
// Depends on ccm_pkg.
module ccm_checker import ccm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output transfer changed while stalled");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.error != ERR_NONE |->
            o_out_item.last && !o_out_item.is_tag && o_out_item.out_byte == 8'h00)
        else $error("error result is malformed");

    a_data_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.is_tag && o_out_item.error == ERR_NONE |->
            !o_out_item.last)
        else $error("data byte flagged as last");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

bind aes_ccm_stream_crypt_core ccm_checker u_ccm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
